>>> design/rpt_pkg.sv
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared widths, operation and status codes, and the control and status
// bundles that pass between the request priority table controller and
// datapath.
// ----------------------------------------------------------------------------
package rpt_pkg;

  localparam int unsigned KindW   = 3;
  localparam int unsigned NameW   = 8;
  localparam int unsigned PrioW   = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned SlotW   = 6;

  // Results reported for one delete or list item.
  localparam int unsigned MaxResults = 64;
  localparam int unsigned ResCntW    = $clog2(MaxResults + 1);

  localparam logic [KindW-1:0] KindInsert   = 3'd0;
  localparam logic [KindW-1:0] KindFindName = 3'd1;
  localparam logic [KindW-1:0] KindFindPrio = 3'd2;
  localparam logic [KindW-1:0] KindDelete   = 3'd3;
  localparam logic [KindW-1:0] KindList     = 3'd4;
  localparam logic [KindW-1:0] KindClear    = 3'd5;

  localparam logic [StatusW-1:0] StatOk       = 2'd0;
  localparam logic [StatusW-1:0] StatNotFound = 2'd1;
  localparam logic [StatusW-1:0] StatFull     = 2'd2;
  localparam logic [StatusW-1:0] StatBadPrio  = 2'd3;

  localparam logic [PrioW-1:0] PrioMin = 3'd1;
  localparam logic [PrioW-1:0] PrioMax = 3'd4;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [SlotW-1:0]   slot;
    logic [NameW-1:0]   name;
    logic [PrioW-1:0]   prio;
  } res_t;

  typedef struct packed {
    logic               load;
    logic               insert;
    logic               clear;
    logic               post;
    logic [StatusW-1:0] post_code;
    logic               scan_begin;
    logic               scan_run;
    logic               flush;
  } dp_cmd_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             prio_ok;
    logic             full;
    logic             name_zero;
    logic             fill_zero;
    logic             scan_done;
    logic             out_free;
  } dp_status_t;

endpackage

>>> design/rpt_ram.sv
// ----------------------------------------------------------------------------
// rpt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold the read data while no read is requested.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/rpt_datapath.sv
// ----------------------------------------------------------------------------
// rpt_datapath
// Slot storage (RAM plus per-slot valid bits), fill count, scan pipeline,
// pending result register and output register of the request priority table.
// ----------------------------------------------------------------------------
module rpt_datapath #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [rpt_pkg::KindW-1:0]          kind_i,
  input  logic [rpt_pkg::NameW-1:0]          req_name_i,
  input  logic [rpt_pkg::PrioW-1:0]          req_priority_i,
  input  rpt_pkg::dp_cmd_t                   cmd_i,
  output rpt_pkg::dp_status_t                status_o,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [rpt_pkg::StatusW-1:0]        res_status_o,
  output logic [rpt_pkg::SlotW-1:0]          slot_o,
  output logic [rpt_pkg::NameW-1:0]          slot_name_o,
  output logic [rpt_pkg::PrioW-1:0]          slot_priority_o,
  output logic                               last_o
);
  import rpt_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned EntW = NameW + PrioW;

  function automatic logic [SlotW-1:0] to_slot(input logic [IdxW-1:0] idx);
    logic [IdxW+SlotW-1:0] ext;
    ext = {{SlotW{1'b0}}, idx};
    return ext[SlotW-1:0];
  endfunction

  logic [KindW-1:0]   kind_q;
  logic [NameW-1:0]   name_q;
  logic [PrioW-1:0]   prio_q;
  logic [CntW-1:0]    fill_q;
  logic [CAPACITY-1:0] valid_q;
  logic [CntW-1:0]    iss_q;
  logic               eval_vld_q;
  logic [IdxW-1:0]    eval_idx_q;
  logic               fin_q;
  logic [ResCntW-1:0] n_q;
  logic               pend_vld_q;
  res_t               pend_q;
  logic               out_vld_q;
  res_t               out_q;
  logic               out_last_q;

  logic [EntW-1:0]    ram_rdata;
  logic               ent_v;
  logic [NameW-1:0]   ent_name;
  logic [PrioW-1:0]   ent_prio;
  logic               is_find;
  logic               is_prio_scan;
  logic               name_hit;
  logic               prio_hit;
  logic               report;
  logic               scan_act;
  logic               stall;
  logic               advance;
  logic               iss_more;
  logic               rd_en;
  logic               fin_set;
  logic               out_free;
  logic               out_load_mid;
  logic               out_load_fin;
  logic [IdxW-1:0]    fill_idx;

  assign fill_idx = fill_q[IdxW-1:0];

  rpt_ram #(
    .WIDTH(EntW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.insert),
    .waddr_i(fill_idx),
    .wdata_i({name_q, prio_q}),
    .re_i   (rd_en),
    .raddr_i(iss_q[IdxW-1:0]),
    .rdata_o(ram_rdata)
  );

  // An emptied or never written slot reads as name zero, priority zero.
  assign ent_v    = valid_q[eval_idx_q];
  assign ent_name = ent_v ? ram_rdata[EntW-1:PrioW] : '0;
  assign ent_prio = ent_v ? ram_rdata[PrioW-1:0] : '0;

  assign is_find      = (kind_q == KindFindName) || (kind_q == KindFindPrio);
  assign is_prio_scan = (kind_q == KindDelete) || (kind_q == KindList);
  assign name_hit     = eval_vld_q && is_find && (ent_name == name_q);
  assign prio_hit     = eval_vld_q && is_prio_scan && (ent_prio == prio_q);
  assign report       = prio_hit && (n_q < ResCntW'(MaxResults));

  assign out_free = !out_vld_q || out_ready_i;
  assign scan_act = cmd_i.scan_run && !fin_q;
  // Stall when a new match must push the held result out and the output is busy.
  assign stall    = report && pend_vld_q && !out_free;
  assign advance  = scan_act && !stall;
  assign iss_more = iss_q < fill_q;
  assign rd_en    = advance && iss_more;
  assign fin_set  = advance && (name_hit || !iss_more);

  assign out_load_mid = advance && report && pend_vld_q;
  assign out_load_fin = cmd_i.flush && out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      name_q <= req_name_i;
      prio_q <= req_priority_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      valid_q <= '0;
    end else if (cmd_i.clear) begin
      fill_q  <= '0;
      valid_q <= '0;
    end else if (cmd_i.insert) begin
      fill_q            <= fill_q + CntW'(1);
      valid_q[fill_idx] <= 1'b1;
    end else if (advance && prio_hit && (kind_q == KindDelete)) begin
      valid_q[eval_idx_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q      <= '0;
      eval_vld_q <= 1'b0;
      eval_idx_q <= '0;
      fin_q      <= 1'b0;
      n_q        <= '0;
    end else if (cmd_i.scan_begin) begin
      iss_q      <= '0;
      eval_vld_q <= 1'b0;
      fin_q      <= 1'b0;
      n_q        <= '0;
    end else if (advance) begin
      if (rd_en) begin
        iss_q      <= iss_q + CntW'(1);
        eval_idx_q <= iss_q[IdxW-1:0];
      end
      eval_vld_q <= rd_en;
      if (fin_set) begin
        fin_q <= 1'b1;
      end
      if (report) begin
        n_q <= n_q + ResCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      pend_q     <= '0;
    end else if (cmd_i.post) begin
      pend_vld_q <= 1'b1;
      pend_q     <= '{status: cmd_i.post_code, default: '0};
    end else if (cmd_i.insert) begin
      pend_vld_q <= 1'b1;
      pend_q     <= '{status: StatOk, slot: to_slot(fill_idx), name: name_q, prio: prio_q};
    end else if (cmd_i.clear) begin
      pend_vld_q <= 1'b1;
      pend_q     <= '{status: StatOk, default: '0};
    end else if (cmd_i.scan_begin) begin
      pend_vld_q <= 1'b0;
    end else if (advance && name_hit) begin
      pend_vld_q <= 1'b1;
      // Only the lowest slot with the name is checked against the priority.
      if ((kind_q == KindFindPrio) && (ent_prio != prio_q)) begin
        pend_q <= '{status: StatNotFound, default: '0};
      end else begin
        pend_q <= '{status: StatOk, slot: to_slot(eval_idx_q), name: ent_name,
                    prio: ent_prio};
      end
    end else if (advance && report) begin
      pend_vld_q <= 1'b1;
      pend_q     <= '{status: StatOk, slot: to_slot(eval_idx_q), name: ent_name,
                      prio: ent_prio};
    end else if (fin_set && !pend_vld_q) begin
      pend_vld_q <= 1'b1;
      pend_q     <= '{status: StatNotFound, default: '0};
    end else if (out_load_fin) begin
      pend_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      out_q      <= '0;
      out_last_q <= 1'b0;
    end else if (out_load_mid) begin
      out_vld_q  <= 1'b1;
      out_q      <= pend_q;
      out_last_q <= 1'b0;
    end else if (out_load_fin) begin
      out_vld_q  <= 1'b1;
      out_q      <= pend_q;
      out_last_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign status_o.kind      = kind_q;
  assign status_o.prio_ok   = prio_q inside {[PrioMin:PrioMax]};
  assign status_o.full      = (fill_q == CntW'(CAPACITY));
  assign status_o.name_zero = (name_q == '0);
  assign status_o.fill_zero = (fill_q == '0);
  assign status_o.scan_done = fin_q;
  assign status_o.out_free  = out_free;

  assign out_valid_o     = out_vld_q;
  assign res_status_o    = out_q.status;
  assign slot_o          = out_q.slot;
  assign slot_name_o     = out_q.name;
  assign slot_priority_o = out_q.prio;
  assign last_o          = out_last_q;

endmodule

>>> design/rpt_ctrl.sv
// ----------------------------------------------------------------------------
// rpt_ctrl
// Controller of the request priority table: takes one item at a time,
// decodes its kind and sequences the datapath through execute, scan and
// result flush.
// ----------------------------------------------------------------------------
module rpt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rpt_pkg::dp_status_t status_i,
  output rpt_pkg::dp_cmd_t    cmd_o
);
  import rpt_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StExec  = 2'd1;
  localparam logic [1:0] StScan  = 2'd2;
  localparam logic [1:0] StFlush = 2'd3;

  logic [1:0] state_q;
  logic [1:0] state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StExec;
        end
      end
      StExec: begin
        state_d = StFlush;
        case (status_i.kind)
          KindInsert: begin
            if (!status_i.prio_ok) begin
              cmd_o.post      = 1'b1;
              cmd_o.post_code = StatBadPrio;
            end else if (status_i.full) begin
              cmd_o.post      = 1'b1;
              cmd_o.post_code = StatFull;
            end else begin
              cmd_o.insert = 1'b1;
            end
          end
          KindFindName, KindFindPrio: begin
            if ((status_i.kind == KindFindPrio) && !status_i.prio_ok) begin
              cmd_o.post      = 1'b1;
              cmd_o.post_code = StatBadPrio;
            end else if (status_i.name_zero || status_i.fill_zero) begin
              cmd_o.post      = 1'b1;
              cmd_o.post_code = StatNotFound;
            end else begin
              cmd_o.scan_begin = 1'b1;
              state_d          = StScan;
            end
          end
          KindDelete, KindList: begin
            if (!status_i.prio_ok) begin
              cmd_o.post      = 1'b1;
              cmd_o.post_code = StatBadPrio;
            end else if (status_i.fill_zero) begin
              cmd_o.post      = 1'b1;
              cmd_o.post_code = StatNotFound;
            end else begin
              cmd_o.scan_begin = 1'b1;
              state_d          = StScan;
            end
          end
          KindClear: begin
            cmd_o.clear = 1'b1;
          end
          default: begin
            // Unused kinds: drop the item, no result.
            state_d = StIdle;
          end
        endcase
      end
      StScan: begin
        cmd_o.scan_run = 1'b1;
        if (status_i.scan_done) begin
          state_d = StFlush;
        end
      end
      StFlush: begin
        cmd_o.flush = 1'b1;
        if (status_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/request_priority_table_top.sv
// ----------------------------------------------------------------------------
// request_priority_table_top
// Table of request slots: insert, find by name or name and priority, delete
// and list by priority, clear. Controller and datapath: slot RAM, valid bits.
// ----------------------------------------------------------------------------
// Order: insert, clear and rejected items go from execute to flush; find,
//   delete and list scan the filled slots one slot per cycle, slower while
//   the output stalls, then flush.
// Throughput: one item at a time; the next item is taken once the last
//   result has entered the output register.
// Reset: table empty, fill count zero; per-slot valid bits clear at once.
module request_priority_table_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rpt_pkg::KindW-1:0]   kind_i,
  input  logic [rpt_pkg::NameW-1:0]   req_name_i,
  input  logic [rpt_pkg::PrioW-1:0]   req_priority_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rpt_pkg::StatusW-1:0] status_o,
  output logic [rpt_pkg::SlotW-1:0]   slot_o,
  output logic [rpt_pkg::NameW-1:0]   slot_name_o,
  output logic [rpt_pkg::PrioW-1:0]   slot_priority_o,
  output logic                        last_o
);
  import rpt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t dp_status;

  rpt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (dp_status),
    .cmd_o     (cmd)
  );

  rpt_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .kind_i         (kind_i),
    .req_name_i     (req_name_i),
    .req_priority_i (req_priority_i),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .res_status_o   (status_o),
    .slot_o         (slot_o),
    .slot_name_o    (slot_name_o),
    .slot_priority_o(slot_priority_o),
    .last_o         (last_o)
  );

endmodule
